/* rtl/fpca_pkg.sv */
// ----------------------------------------------------------------------------
// fpca_pkg
// Types and constants shared by the fit-policy cell allocator and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpca_pkg;

    localparam int CELL_COUNT_DEF = 1024;

    // register file: one register, fit_policy, at byte address 0
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-3:0] REG_FIT_POLICY = '0;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        CELL_FREE = 2'd0,
        CELL_USED = 2'd1,
        CELL_END  = 2'd2
    } cell_t;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_NEXT  = 2'd1,
        POL_BEST  = 2'd2,
        POL_WORST = 2'd3
    } pol_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_SCAN,
        ST_MARK,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       kind;
        logic [9:0] request_size;
        logic [9:0] free_address;
    } req_t;

    typedef struct packed {
        logic       granted;
        logic [9:0] block_start;
    } rsp_t;

endpackage

/* rtl/fit_policy_cell_allocator_top.sv */
// ----------------------------------------------------------------------------
// fit_policy_cell_allocator_top
// Cell map allocator with first, next, best and worst fit search.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_stall/req) takes one item at a time: an
// allocate of request_size+1 contiguous cells, or a free from free_address
// up to the next end-of-block cell. Each item gives one result item on the
// rsp channel (granted, block_start). The user must set fit_policy over the
// APB port only while the block is idle; the block does not enforce this.
// All work goes through one cell map RAM (one read, one write port) under a
// small sequencer, so timing follows the number of cells touched:
//   allocate: fetch, scan, mark and done states; the scan runs from the
//             start cell to the end of the map (first/next fit stop at the
//             first fitting run), at most CELL_COUNT+1 cells, and marking
//             writes request_size+1 cells.
//   free:     fetch, then a walk that clears cells, then done.
// req_stall is high from acceptance until the result is loaded into the
// output register. A held result (rsp_stall high) does not block a new item
// from being accepted; it only delays the finish of that item.
// After reset the map is cleared one cell a cycle with req_stall high;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fit_policy_cell_allocator_top
    import fpca_pkg::*;
#(
    parameter int CELL_COUNT = CELL_COUNT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               req_valid,
    output logic               req_stall,
    input  req_t               req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_t               rsp
);

    localparam int IDX_W = $clog2(CELL_COUNT);
    localparam int CNT_W = $clog2(CELL_COUNT + 1);
    localparam int CMP_W = (CNT_W > 11) ? CNT_W : 11;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CELL_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(CELL_COUNT);

    // control
    state_t            state_reg, state_next;
    pol_t              pol_reg;
    logic [IDX_W-1:0]  cursor_reg, cursor_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // payload / datapath
    logic              kind_reg, kind_next;
    logic [10:0]       need_reg, need_next;
    logic [10:0]       left_reg, left_next;
    logic [IDX_W-1:0]  run_start_reg, run_start_next;
    logic [CNT_W-1:0]  run_len_reg, run_len_next;
    logic [IDX_W-1:0]  pick_start_reg, pick_start_next;
    logic [CNT_W-1:0]  pick_len_reg, pick_len_next;
    logic              found_reg, found_next;
    logic              granted_reg, granted_next;
    logic [9:0]        start_reg, start_next;
    rsp_t              rsp_reg, rsp_next;

    // cell map
    logic [1:0]        mem [CELL_COUNT];
    logic [1:0]        rd_data_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    cell_t             mem_wdata;

    logic              cfg_wr;
    logic              at_end, cell_free, fits, better, load_rsp;
    logic [CNT_W-1:0]  idx_inc;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pol_reg <= POL_FIRST;
        end
        else if (cfg_wr && paddr[PADDR_W-1:2] == REG_FIT_POLICY)
        begin
            pol_reg <= pol_t'(pwdata[1:0]);
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[PADDR_W-1:2] == REG_FIT_POLICY)
        begin
            prdata = {30'd0, pol_reg};
        end
    end

    // ---------------- cell map RAM ----------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // ---------------- sequencer ----------------
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign at_end    = (idx_reg == CNT_END);
    assign cell_free = !at_end && (rd_data_reg == CELL_FREE);
    assign fits      = CMP_W'(run_len_reg) >= CMP_W'(need_reg);
    assign better    = !found_reg
                    || (pol_reg == POL_BEST  && run_len_reg < pick_len_reg)
                    || (pol_reg == POL_WORST && run_len_reg > pick_len_reg);
    assign load_rsp  = (state_reg == ST_DONE) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        idx_next        = idx_reg;
        kind_next       = kind_reg;
        need_next       = need_reg;
        left_next       = left_reg;
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        pick_start_next = pick_start_reg;
        pick_len_next   = pick_len_reg;
        found_next      = found_reg;
        granted_next    = granted_reg;
        start_next      = start_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg[IDX_W-1:0];
        mem_wdata       = CELL_FREE;
        mem_raddr       = idx_reg[IDX_W-1:0];

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                idx_next = idx_inc;
                if (idx_reg == CNT_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next    = req.kind;
                    need_next    = {1'b0, req.request_size} + 11'd1;
                    run_len_next = '0;
                    found_next   = 1'b0;
                    start_next   = '0;
                    if (req.kind == KIND_ALLOC)
                    begin
                        idx_next   = (pol_reg == POL_NEXT) ? CNT_W'(cursor_reg) : '0;
                        state_next = ST_FETCH;
                    end
                    else if (CMP_W'(req.free_address) < CMP_W'(CELL_COUNT))
                    begin
                        idx_next   = CNT_W'(req.free_address);
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        // address beyond the map: nothing to clear
                        granted_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                end
            end

            ST_FETCH:
            begin
                state_next = (kind_reg == KIND_ALLOC) ? ST_SCAN : ST_WALK;
            end

            ST_SCAN:
            begin
                // read one cell ahead; position CELL_COUNT closes the last run
                mem_raddr = (idx_inc < CNT_END) ? idx_inc[IDX_W-1:0] : '0;
                idx_next  = idx_inc;
                if (cell_free)
                begin
                    if (run_len_reg == '0)
                    begin
                        run_start_next = idx_reg[IDX_W-1:0];
                    end
                    run_len_next = run_len_reg + CNT_W'(1);
                end
                else
                begin
                    run_len_next = '0;
                    if (fits && (pol_reg == POL_FIRST || pol_reg == POL_NEXT))
                    begin
                        pick_start_next = run_start_reg;
                        idx_next        = CNT_W'(run_start_reg);
                        left_next       = need_reg;
                        state_next      = ST_MARK;
                    end
                    else
                    begin
                        if (fits && better)
                        begin
                            pick_start_next = run_start_reg;
                            pick_len_next   = run_len_reg;
                            found_next      = 1'b1;
                        end
                        if (at_end)
                        begin
                            if (found_next)
                            begin
                                idx_next   = CNT_W'(pick_start_next);
                                left_next  = need_reg;
                                state_next = ST_MARK;
                            end
                            else
                            begin
                                granted_next = 1'b0;
                                state_next   = ST_DONE;
                            end
                        end
                    end
                end
            end

            ST_MARK:
            begin
                mem_we    = 1'b1;
                mem_wdata = (left_reg == 11'd1) ? CELL_END : CELL_USED;
                idx_next  = idx_inc;
                left_next = left_reg - 11'd1;
                if (left_reg == 11'd1)
                begin
                    if (pol_reg == POL_NEXT)
                    begin
                        cursor_next = idx_reg[IDX_W-1:0];
                    end
                    granted_next = 1'b1;
                    start_next   = 10'(pick_start_reg);
                    state_next   = ST_DONE;
                end
            end

            ST_WALK:
            begin
                mem_we = 1'b1;
                if (rd_data_reg == CELL_END || idx_reg == CNT_LAST)
                begin
                    granted_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    idx_next  = idx_inc;
                    mem_raddr = idx_inc[IDX_W-1:0];
                end
            end

            ST_DONE:
            begin
                if (load_rsp)
                begin
                    rsp_next.granted     = granted_reg;
                    rsp_next.block_start = start_reg;
                    rsp_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cursor_reg    <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        need_reg       <= need_next;
        left_reg       <= left_next;
        run_start_reg  <= run_start_next;
        run_len_reg    <= run_len_next;
        pick_start_reg <= pick_start_next;
        pick_len_reg   <= pick_len_next;
        found_reg      <= found_next;
        granted_reg    <= granted_next;
        start_reg      <= start_next;
        rsp_reg        <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* rtl/fpca_checker.sv */
// ----------------------------------------------------------------------------
// fpca_checker
// Port-level checks for the fit-policy cell allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpca_checker
    import fpca_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // a held result item keeps its value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result item changed while stalled");

    // one item at a time: busy straight after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken again without finishing the item");

    // a new result only comes out of a busy cycle
    a_rsp_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result item appeared while idle");

    // failure carries no start cell
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.granted |-> rsp.block_start == 10'd0)
        else $error("failed allocation with non-zero start");

endmodule

bind fit_policy_cell_allocator_top fpca_checker u_fpca_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the fit-policy cell allocator against a cycle-free cell map model.
// A short directed plan walks the corner cases under all four fit policies.
// Random phases of allocate and free items follow, one policy per phase.
// Every result item is compared, in order, with the model's prediction or the plan's fixed result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import fpca_pkg::*;

    localparam int CELLS = CELL_COUNT_DEF;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 64;

    typedef struct packed {
        pol_t       pol;
        logic       kind;
        logic [9:0] size;
        logic [9:0] addr;
        logic       fixed_rsp;
        logic       granted;
        logic [9:0] start;
    } plan_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               req_valid = 1'b0;
    logic               req_stall;
    req_t               req = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    rsp_t               rsp;

    // cell map shadow
    cell_t cell_map [CELLS];
    int    next_cursor = 0;
    pol_t  fit_mode = POL_FIRST;
    int    block_starts [$];

    rsp_t  pending_rsp [$];
    int    fail_count = 0;
    int    n_alloc = 0;
    int    n_alloc_ok = 0;
    int    n_free = 0;
    int    n_cfg = 0;
    bit    idle_on = 1'b1;
    int    stall_left = 0;
    int    stall_len;

    fit_policy_cell_allocator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    initial
    begin
        foreach (cell_map[i])
            cell_map[i] = CELL_FREE;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    // apply one item to the shadow map, return the result it gives
    function automatic rsp_t alloc_or_free(req_t item);
        rsp_t  res;
        int    need;
        int    i;
        int    run_start;
        int    run_len;
        int    pick_start;
        int    pick_len;
        int    last;
        bit    found;
        bit    done;
        cell_t was;

        res = '0;
        if (item.kind == KIND_ALLOC)
        begin
            need = int'(item.request_size) + 1;
            run_start = 0;
            run_len = 0;
            pick_start = 0;
            pick_len = 0;
            found = 1'b0;
            done = 1'b0;
            // one step past the last cell closes a run that reaches the end
            for (i = (fit_mode == POL_NEXT) ? next_cursor : 0; i <= CELLS && !done; i++)
            begin
                if (i < CELLS && cell_map[i] == CELL_FREE)
                begin
                    if (run_len == 0)
                        run_start = i;
                    run_len++;
                end
                else
                begin
                    if (run_len >= need)
                    begin
                        if (fit_mode == POL_FIRST || fit_mode == POL_NEXT)
                        begin
                            pick_start = run_start;
                            found = 1'b1;
                            done = 1'b1;
                        end
                        else if (!found ||
                                 (fit_mode == POL_BEST && run_len < pick_len) ||
                                 (fit_mode == POL_WORST && run_len > pick_len))
                        begin
                            pick_start = run_start;
                            pick_len = run_len;
                            found = 1'b1;
                        end
                    end
                    run_len = 0;
                end
            end
            if (found)
            begin
                last = pick_start + need - 1;
                for (i = pick_start; i < last; i++)
                    cell_map[i] = CELL_USED;
                cell_map[last] = CELL_END;
                if (fit_mode == POL_NEXT)
                    next_cursor = last;
                res.granted = 1'b1;
                res.block_start = 10'(pick_start);
            end
        end
        else
        begin
            i = int'(item.free_address);
            done = 1'b0;
            while (i < CELLS && !done)
            begin
                was = cell_map[i];
                cell_map[i] = CELL_FREE;
                if (was == CELL_END)
                    done = 1'b1;
                i++;
            end
            res.granted = 1'b1;
        end
        return res;
    endfunction

    // start cells of live blocks, for well-formed frees
    function automatic void collect_blocks();
        block_starts.delete();
        for (int i = 0; i < CELLS; i++)
            if (cell_map[i] != CELL_FREE && (i == 0 || cell_map[i-1] != CELL_USED))
                block_starts.push_back(i);
    endfunction

    task automatic wait_drained();
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_policy(input pol_t pol);
        // no item may be offered while the policy changes
        req_valid <= 1'b0;
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_FIT_POLICY, 2'b00};
        pwdata <= 32'(pol);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        fit_mode = pol;
        n_cfg++;
    endtask

    task automatic send_req(input req_t item, input logic use_fixed, input rsp_t fixed);
        rsp_t predicted;
        int   gap_len;

        req <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        predicted = alloc_or_free(item);
        pending_rsp.push_back(use_fixed ? fixed : predicted);
        if (item.kind == KIND_ALLOC)
        begin
            n_alloc++;
            if (predicted.granted)
                n_alloc_ok++;
        end
        else
            n_free++;
        gap_len = pick_gap();
        if (gap_len != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap_len) @(posedge clk);
        end
    endtask

    // result side: check and random stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $display("%0t: unexpected result item, expected none, got granted=%0b start=%0d",
                             $time, rsp.granted, rsp.block_start);
                    fail_count++;
                end
                else
                begin
                    if (rsp.granted !== pending_rsp[0].granted)
                    begin
                        $display("%0t: granted mismatch, expected %0b, got %0b",
                                 $time, pending_rsp[0].granted, rsp.granted);
                        fail_count++;
                    end
                    if (rsp.block_start !== pending_rsp[0].block_start)
                    begin
                        $display("%0t: block_start mismatch, expected %0d, got %0d",
                                 $time, pending_rsp[0].block_start, rsp.block_start);
                        fail_count++;
                    end
                    void'(pending_rsp.pop_front());
                end
            end
            if (stall_left != 0)
            begin
                stall_left = stall_left - 1;
                rsp_stall <= 1'b1;
            end
            else
            begin
                stall_len = pick_gap();
                rsp_stall <= (stall_len != 0);
                stall_left = (stall_len != 0) ? stall_len - 1 : 0;
            end
        end
    end

    initial
    begin
        #80_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        plan_row_t plan [$];
        req_t      item;
        rsp_t      fixed;
        pol_t      pol;
        int        sel;

        plan = '{
            '{POL_FIRST, KIND_ALLOC, 10'd0,    10'd0,    1'b1, 1'b1, 10'd0},
            '{POL_FIRST, KIND_ALLOC, 10'd3,    10'd0,    1'b1, 1'b1, 10'd1},
            '{POL_FIRST, KIND_FREE,  10'd0,    10'd0,    1'b1, 1'b1, 10'd0},
            '{POL_FIRST, KIND_ALLOC, 10'd0,    10'd0,    1'b1, 1'b1, 10'd0},
            // free at a free cell with no end marker after it
            '{POL_FIRST, KIND_FREE,  10'd0,    10'd1023, 1'b1, 1'b1, 10'd0},
            // free from the middle of a block
            '{POL_FIRST, KIND_FREE,  10'd0,    10'd2,    1'b1, 1'b1, 10'd0},
            '{POL_FIRST, KIND_ALLOC, 10'd1023, 10'd0,    1'b1, 1'b0, 10'd0},
            '{POL_FIRST, KIND_FREE,  10'd0,    10'd1,    1'b1, 1'b1, 10'd0},
            '{POL_FIRST, KIND_FREE,  10'd0,    10'd0,    1'b1, 1'b1, 10'd0},
            // whole map in one block, then nothing fits
            '{POL_FIRST, KIND_ALLOC, 10'd1023, 10'd0,    1'b1, 1'b1, 10'd0},
            '{POL_FIRST, KIND_ALLOC, 10'd0,    10'd0,    1'b1, 1'b0, 10'd0},
            '{POL_FIRST, KIND_FREE,  10'd0,    10'd0,    1'b1, 1'b1, 10'd0},
            '{POL_NEXT,  KIND_ALLOC, 10'd9,    10'd0,    1'b1, 1'b1, 10'd0},
            '{POL_NEXT,  KIND_ALLOC, 10'd0,    10'd0,    1'b1, 1'b1, 10'd10},
            '{POL_NEXT,  KIND_ALLOC, 10'd1013, 10'd0,    1'b1, 1'b0, 10'd0},
            '{POL_NEXT,  KIND_FREE,  10'd0,    10'd0,    1'b1, 1'b1, 10'd0},
            // next fit does not wrap back to the freed cells
            '{POL_NEXT,  KIND_ALLOC, 10'd0,    10'd0,    1'b1, 1'b1, 10'd11},
            '{POL_BEST,  KIND_ALLOC, 10'd4,    10'd0,    1'b1, 1'b1, 10'd0},
            '{POL_WORST, KIND_ALLOC, 10'd4,    10'd0,    1'b0, 1'b0, 10'd0},
            '{POL_BEST,  KIND_ALLOC, 10'd4,    10'd0,    1'b0, 1'b0, 10'd0},
            '{POL_BEST,  KIND_ALLOC, 10'd1023, 10'd0,    1'b1, 1'b0, 10'd0},
            // worst fit on a run that reaches the last cell
            '{POL_WORST, KIND_ALLOC, 10'd1006, 10'd0,    1'b0, 1'b0, 10'd0},
            '{POL_WORST, KIND_FREE,  10'd0,    10'd17,   1'b1, 1'b1, 10'd0},
            '{POL_FIRST, KIND_ALLOC, 10'd0,    10'd0,    1'b1, 1'b1, 10'd17},
            '{POL_FIRST, KIND_FREE,  10'd0,    10'd1023, 1'b1, 1'b1, 10'd0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_policy(POL_FIRST);

        foreach (plan[j])
        begin
            if (plan[j].pol != fit_mode)
                set_policy(plan[j].pol);
            item.kind = plan[j].kind;
            item.request_size = plan[j].size;
            item.free_address = plan[j].addr;
            fixed.granted = plan[j].granted;
            fixed.block_start = plan[j].start;
            send_req(item, plan[j].fixed_rsp, fixed);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: pol = POL_FIRST;
                1: pol = POL_NEXT;
                2: pol = POL_BEST;
                3: pol = POL_WORST;
                default: pol = pol_t'($urandom_range(0, 3));
            endcase
            idle_on = (ph != 2);
            set_policy(pol);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                collect_blocks();
                sel = $urandom_range(0, 99);
                item.kind = KIND_ALLOC;
                item.request_size = 10'($urandom);
                item.free_address = 10'($urandom);
                if (sel < 45)
                    item.request_size = 10'($urandom_range(0, 15));
                else if (sel < 55)
                    item.request_size = 10'($urandom_range(16, 127));
                else if (sel < 58)
                    item.request_size = 10'($urandom_range(128, 1023));
                else if (sel < 88 && block_starts.size() != 0)
                begin
                    item.kind = KIND_FREE;
                    item.free_address =
                        10'(block_starts[$urandom_range(0, block_starts.size() - 1)]);
                end
                else if (sel < 95 || block_starts.size() == 0)
                begin
                    item.kind = KIND_FREE;
                    item.free_address = 10'($urandom_range(0, CELLS - 1));
                end
                else
                begin
                    // start part way into a block
                    item.kind = KIND_FREE;
                    item.free_address =
                        10'(block_starts[$urandom_range(0, block_starts.size() - 1)]
                            + $urandom_range(1, 3));
                end
                send_req(item, 1'b0, '0);
            end
        end

        req_valid <= 1'b0;
        wait_drained();
        repeat (64) @(posedge clk);

        $display("Covered %0d items: %0d allocations (%0d granted) and %0d frees",
                 n_alloc + n_free, n_alloc, n_alloc_ok, n_free);
        $display("Fit policy written %0d times over first, next, best and worst fit", n_cfg);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
